>>> sv/sgmix_pkg.sv
// Package for the stereo PCM16 gain and saturating mix core.
// Holds the word types, register indexes, reset values and the 16-bit clip.
// No dependencies.
`default_nettype none

package sgmix_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 6;
  localparam int WIDE_W   = 19;
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_GAIN_LEFT  = 2'd0;
  localparam cfg_idx_t CFG_GAIN_RIGHT = 2'd1;
  localparam cfg_idx_t CFG_MIX_MODE   = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 6'd16;

  localparam logic signed [WIDE_W-1:0] PCM_MAX_W = 19'sd32767;
  localparam logic signed [WIDE_W-1:0] PCM_MIN_W = -19'sd32768;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] source_sample;
    logic signed [SAMPLE_W-1:0] dest_sample;
    logic                       channel;
    logic                       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] result_sample;
    logic                       end_of_buffer_out;
  } out_word_t;

  function automatic logic signed [SAMPLE_W-1:0] clip16(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    begin
      if (v < PCM_MIN_W) begin
        c = PCM_MIN_W;
      end else if (v > PCM_MAX_W) begin
        c = PCM_MAX_W;
      end else begin
        c = v;
      end
      return c[SAMPLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/stereo_pcm16_gain_and_saturating_mix_core.sv
// Top level of the stereo PCM16 gain and saturating mix core.
// Depends on sgmix_pkg and sgmix_scale.
// An accepted word is held in stage_r, scaled and mixed combinationally, and registered into out_r with out_valid.
// Throughput: one word per clock; busy stays low, so start may be held high.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset sets both gains to unity (16), selects mix mode and clears the pipeline valid flags.
`default_nettype none

module stereo_pcm16_gain_and_saturating_mix_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire sgmix_pkg::in_word_t                 in_data,
  output logic                                     out_valid,
  output sgmix_pkg::out_word_t                     out_data,
  input  wire logic                                cfg_we,
  input  wire sgmix_pkg::cfg_idx_t                 cfg_index,
  input  wire logic [sgmix_pkg::GAIN_W-1:0]        cfg_data
);

  logic [sgmix_pkg::GAIN_W-1:0] gain_left_r;
  logic [sgmix_pkg::GAIN_W-1:0] gain_right_r;
  logic                         mix_mode_r;

  sgmix_pkg::in_word_t  stage_r;
  logic                 stage_valid_r;
  sgmix_pkg::out_word_t out_r;
  sgmix_pkg::out_word_t out_nxt;
  logic                 out_valid_r;

  logic [sgmix_pkg::GAIN_W-1:0]          gain_sel;
  logic signed [sgmix_pkg::SAMPLE_W-1:0] scaled;
  logic signed [sgmix_pkg::WIDE_W-1:0]   sum;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_left_r  <= sgmix_pkg::GAIN_UNITY;
      gain_right_r <= sgmix_pkg::GAIN_UNITY;
      mix_mode_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        sgmix_pkg::CFG_GAIN_LEFT:  gain_left_r  <= cfg_data;
        sgmix_pkg::CFG_GAIN_RIGHT: gain_right_r <= cfg_data;
        sgmix_pkg::CFG_MIX_MODE:   mix_mode_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= start && !busy;
      out_valid_r   <= stage_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      stage_r <= in_data;
    end
    if (stage_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign gain_sel = stage_r.channel ? gain_right_r : gain_left_r;

  sgmix_scale u_scale (
    .sample (stage_r.source_sample),
    .gain   (gain_sel),
    .scaled (scaled)
  );

  assign sum = sgmix_pkg::WIDE_W'(stage_r.dest_sample) + sgmix_pkg::WIDE_W'(scaled);

  always_comb begin
    out_nxt.end_of_buffer_out = stage_r.end_of_buffer;
    if (mix_mode_r) begin
      out_nxt.result_sample = sgmix_pkg::clip16(sum);
    end else if (gain_left_r == '0 && gain_right_r == '0) begin
      out_nxt.result_sample = stage_r.dest_sample;
    end else begin
      out_nxt.result_sample = scaled;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid)
    else $error("accepted word produced no result");

  a_eob_carried: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_data.end_of_buffer_out == $past(in_data.end_of_buffer, 2))
    else $error("end of buffer mark not carried to the result");

  a_zero_gain_pass: assert property (@(posedge clk) disable iff (!rst_n)
    stage_valid_r && !mix_mode_r && gain_left_r == '0 && gain_right_r == '0
    |=> out_data.result_sample == $past(stage_r.dest_sample))
    else $error("destination not passed through with both gains zero");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(stage_valid_r))
    else $error("result strobe without a word in the stage");

endmodule

`default_nettype wire

>>> sv/sgmix_scale.sv
// Gain stage: scales one sample by a table of gain steps built from shift-add terms, with 16 as unity.
// Depends on sgmix_pkg for widths and the clip function.
`default_nettype none

module sgmix_scale (
  input  wire logic signed [sgmix_pkg::SAMPLE_W-1:0] sample,
  input  wire logic        [sgmix_pkg::GAIN_W-1:0]   gain,
  output logic signed      [sgmix_pkg::SAMPLE_W-1:0] scaled
);

  logic signed [sgmix_pkg::WIDE_W-1:0] s;
  logic signed [sgmix_pkg::WIDE_W-1:0] a1;
  logic signed [sgmix_pkg::WIDE_W-1:0] a2;
  logic signed [sgmix_pkg::WIDE_W-1:0] a3;
  logic signed [sgmix_pkg::WIDE_W-1:0] a4;
  logic signed [sgmix_pkg::WIDE_W-1:0] x;

  assign s  = sgmix_pkg::WIDE_W'(sample);
  assign a1 = s >>> 1;
  assign a2 = s >>> 2;
  assign a3 = s >>> 3;
  assign a4 = s >>> 4;

  always_comb begin
    case (gain)
      6'd0:    x = '0;
      6'd1:    x = a4;
      6'd2:    x = a3;
      6'd3:    x = a3 + a4;
      6'd4:    x = a2;
      6'd5:    x = a2 + a4;
      6'd6:    x = a1 - a3;
      6'd7:    x = a1 - a4;
      6'd8:    x = a1;
      6'd9:    x = a1 + a4;
      6'd10:   x = a1 + a3;
      6'd11:   x = s - a2 + a4;
      6'd12:   x = s - a2;
      6'd13:   x = s - a3 + a4;
      6'd14:   x = s - a3;
      6'd15:   x = s - a4;
      6'd16:   x = s;
      6'd17:   x = s + a3 + a4;
      6'd18:   x = s + a2;
      6'd19:   x = s + a1 - a3;
      6'd20:   x = s + a1;
      6'd21:   x = s + a1 + a3;
      6'd22:   x = (s <<< 1) - a2;
      6'd23:   x = (s <<< 1) - a3;
      6'd24:   x = s <<< 1;
      6'd25:   x = (s <<< 1) + a3;
      6'd26:   x = (s <<< 1) + a1;
      6'd27:   x = (s <<< 1) + s - a2;
      6'd28:   x = (s <<< 1) + s;
      6'd29:   x = (s <<< 1) + s + a1;
      6'd30:   x = s <<< 2;
      6'd31:   x = (s <<< 2) + s;
      default: x = (s <<< 2) + (s <<< 1);
    endcase
  end

  assign scaled = sgmix_pkg::clip16(x);

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for stereo_pcm16_gain_and_saturating_mix_core.
// Depends on sgmix_pkg and the core; predicts every result word from a local gain
// and mix model and compares it field by field under changing register settings.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                  STALL_LIMIT   = 2000;
  localparam int                  WORDS_PER_SET = 24;
  localparam int                  RANDOM_SETS   = 40;
  localparam int                  REPORT_CAP    = 50;
  localparam sgmix_pkg::cfg_idx_t CFG_UNUSED    = 2'd3;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  sgmix_pkg::in_word_t          in_data;
  logic                         out_valid;
  sgmix_pkg::out_word_t         out_data;
  logic                         cfg_we;
  sgmix_pkg::cfg_idx_t          cfg_index;
  logic [sgmix_pkg::GAIN_W-1:0] cfg_data;

  sgmix_pkg::in_word_t  sample_pending_q[$];
  sgmix_pkg::out_word_t mixed_expect_q[$];

  logic [sgmix_pkg::GAIN_W-1:0] gain_l_now;
  logic [sgmix_pkg::GAIN_W-1:0] gain_r_now;
  logic                         mix_now;

  int send_gap_pct;
  int mismatch_cnt;
  int samples_sent;
  int results_checked;
  int settings_used;
  int stall_cycles;

  stereo_pcm16_gain_and_saturating_mix_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [15:0] pcm_clip(input int v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] gain_scaled(input logic signed [15:0] s16,
                                                     input logic [sgmix_pkg::GAIN_W-1:0] g6);
    int s;
    int h1;
    int h2;
    int h3;
    int h4;
    int x;
    int g;
    s  = s16;
    h1 = s >>> 1;
    h2 = s >>> 2;
    h3 = s >>> 3;
    h4 = s >>> 4;
    g  = (g6 > 32) ? 32 : int'(g6);
    case (g)
      0:  x = 0;
      1:  x = h4;
      2:  x = h3;
      3:  x = h3 + h4;
      4:  x = h2;
      5:  x = h2 + h4;
      6:  x = h1 - h3;
      7:  x = h1 - h4;
      8:  x = h1;
      9:  x = h1 + h4;
      10: x = h1 + h3;
      11: x = s - h2 + h4;
      12: x = s - h2;
      13: x = s - h3 + h4;
      14: x = s - h3;
      15: x = s - h4;
      16: x = s;
      17: x = s + h3 + h4;
      18: x = s + h2;
      19: x = s + h1 - h3;
      20: x = s + h1;
      21: x = s + h1 + h3;
      22: x = 2 * s - h2;
      23: x = 2 * s - h3;
      24: x = 2 * s;
      25: x = 2 * s + h3;
      26: x = 2 * s + h1;
      27: x = 3 * s - h2;
      28: x = 3 * s;
      29: x = 3 * s + h1;
      30: x = 4 * s;
      31: x = 5 * s;
      default: x = 6 * s;
    endcase
    return pcm_clip(x);
  endfunction

  function automatic sgmix_pkg::out_word_t mixed_sample(input sgmix_pkg::in_word_t w);
    logic signed [15:0]   scaled;
    sgmix_pkg::out_word_t r;
    scaled = gain_scaled(w.source_sample, w.channel ? gain_r_now : gain_l_now);
    if (mix_now) begin
      r.result_sample = pcm_clip(int'(w.dest_sample) + int'(scaled));
    end else if (gain_l_now == 0 && gain_r_now == 0) begin
      r.result_sample = w.dest_sample;
    end else begin
      r.result_sample = scaled;
    end
    r.end_of_buffer_out = w.end_of_buffer;
    return r;
  endfunction

  function automatic logic [15:0] random_pcm();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 16'h7fff;
          1: v = 16'h8000;
          2: v = 16'h0000;
          3: v = 16'hffff;
          default: v = 16'h0001;
        endcase
      end
      1, 2: begin
        v = 16'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) begin
          v = -v;
        end
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_CAP) begin
      $display("%0t MISMATCH %s", $realtime, what);
    end
  endtask

  task automatic queue_sample(input logic [15:0] src, input logic [15:0] dst,
                              input logic ch, input logic eob);
    sgmix_pkg::in_word_t w;
    w.source_sample = src;
    w.dest_sample   = dst;
    w.channel       = ch;
    w.end_of_buffer = eob;
    sample_pending_q.push_back(w);
  endtask

  task automatic write_reg(input sgmix_pkg::cfg_idx_t idx,
                           input logic [sgmix_pkg::GAIN_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_settings(input logic [sgmix_pkg::GAIN_W-1:0] gl,
                                input logic [sgmix_pkg::GAIN_W-1:0] gr,
                                input logic mix);
    write_reg(sgmix_pkg::CFG_GAIN_LEFT, gl);
    write_reg(sgmix_pkg::CFG_GAIN_RIGHT, gr);
    write_reg(sgmix_pkg::CFG_MIX_MODE, {5'($urandom), mix});
    settings_used++;
  endtask

  // Waits until every queued word has been sent and every result has come back.
  task automatic settle();
    do begin
      @(negedge clk);
    end while (sample_pending_q.size() != 0 || start || mixed_expect_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_l_now <= sgmix_pkg::GAIN_UNITY;
      gain_r_now <= sgmix_pkg::GAIN_UNITY;
      mix_now    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        sgmix_pkg::CFG_GAIN_LEFT:  gain_l_now <= cfg_data;
        sgmix_pkg::CFG_GAIN_RIGHT: gain_r_now <= cfg_data;
        sgmix_pkg::CFG_MIX_MODE:   mix_now    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) begin
        mixed_expect_q.push_back(mixed_sample(in_data));
        samples_sent++;
      end
      if (!start || !busy) begin
        if (sample_pending_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          start   <= 1'b1;
          in_data <= sample_pending_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    sgmix_pkg::out_word_t want;
    if (rst_n && out_valid) begin
      if (mixed_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", out_data));
      end else begin
        want = mixed_expect_q.pop_front();
        results_checked++;
        if (out_data.result_sample !== want.result_sample) begin
          report_mismatch($sformatf("result_sample got %0d want %0d",
                                    out_data.result_sample, want.result_sample));
        end
        if (out_data.end_of_buffer_out !== want.end_of_buffer_out) begin
          report_mismatch($sformatf("end_of_buffer_out got %b want %b",
                                    out_data.end_of_buffer_out, want.end_of_buffer_out));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [sgmix_pkg::GAIN_W-1:0] gl;
    logic [sgmix_pkg::GAIN_W-1:0] gr;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = sgmix_pkg::CFG_GAIN_LEFT;
    cfg_data        = '0;
    send_gap_pct    = 0;
    mismatch_cnt    = 0;
    samples_sent    = 0;
    results_checked = 0;
    settings_used   = 1;
    stall_cycles    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    queue_sample(16'h7fff, 16'h7fff, 1'b0, 1'b0);
    queue_sample(16'h8000, 16'h8000, 1'b1, 1'b1);
    queue_sample(16'h0000, 16'h0000, 1'b0, 1'b1);
    queue_sample(16'hffff, 16'h0001, 1'b1, 1'b0);
    queue_sample(16'd12345, -16'sd20000, 1'b0, 1'b0);
    settle();

    apply_settings(6'd32, 6'd63, 1'b0);
    queue_sample(16'h7fff, 16'h0000, 1'b0, 1'b0);
    queue_sample(16'h8000, 16'h0000, 1'b1, 1'b1);
    queue_sample(16'hffff, 16'd5, 1'b0, 1'b0);
    queue_sample(16'd5461, 16'h0000, 1'b1, 1'b0);
    settle();

    apply_settings(6'd0, 6'd0, 1'b0);
    queue_sample(16'd1000, -16'sd123, 1'b0, 1'b1);
    queue_sample(16'h8000, 16'h7fff, 1'b1, 1'b0);
    settle();

    apply_settings(6'd0, 6'd0, 1'b1);
    queue_sample(16'h7fff, 16'h8000, 1'b0, 1'b0);
    settle();

    apply_settings(6'd0, 6'd11, 1'b0);
    write_reg(CFG_UNUSED, 6'h3f);
    queue_sample(16'd20000, 16'd77, 1'b0, 1'b0);
    queue_sample(16'h8000, 16'h0000, 1'b1, 1'b1);
    queue_sample(16'h7fff, 16'h0000, 1'b1, 1'b0);
    settle();

    apply_settings(6'd1, 6'd17, 1'b1);
    queue_sample(16'hffff, 16'h8000, 1'b0, 1'b0);
    queue_sample(16'h7fff, 16'd30000, 1'b1, 1'b1);
    settle();

    for (int p = 0; p < RANDOM_SETS; p++) begin
      if (p <= 32) begin
        gl = 6'(p);
        gr = 6'(32 - p);
      end else begin
        case ($urandom_range(0, 3))
          0: gl = 6'($urandom_range(33, 63));
          1: gl = 6'd32;
          default: gl = 6'($urandom_range(0, 32));
        endcase
        gr = 6'($urandom);
      end
      if (p % 9 == 4) begin
        gl = 6'd0;
        gr = 6'd0;
      end
      apply_settings(gl, gr, 1'($urandom_range(0, 1)));
      case (p % 4)
        0: send_gap_pct = 0;
        1: send_gap_pct = 65;
        2: send_gap_pct = 16;
        default: send_gap_pct = 0;
      endcase
      for (int i = 0; i < WORDS_PER_SET; i++) begin
        queue_sample(random_pcm(), random_pcm(), 1'($urandom), 1'($urandom_range(0, 7) == 0));
      end
      settle();
    end

    $display("Sent %0d samples and checked %0d result words over %0d gain and mode settings.",
             samples_sent, results_checked, settings_used);
    $display("Settings included zero, unity, full and over-range gains in both modes.");
    if (mismatch_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/sgmix_pkg.sv
sv/sgmix_scale.sv
sv/stereo_pcm16_gain_and_saturating_mix_core.sv
tb/tb_top.sv
